/* design/dofd_pkg.sv */
// ----------------------------------------------------------------------------
// Drawing order field decoder package
// Record layout, record kinds, parse phases and the field table of the
// screen copy and cached bitmap copy orders.
// ----------------------------------------------------------------------------
package dofd_pkg;

	typedef enum logic [2:0] {
		KIND_SCOPY   = 3'd0,
		KIND_CCOPY   = 3'd1,
		KIND_CLIP    = 3'd2,
		KIND_SECSKIP = 3'd3,
		KIND_NONSTD  = 3'd4,
		KIND_FCOUNT  = 3'd5,
		KIND_UNSUP   = 3'd6,
		KIND_SHORT   = 3'd7
	} rec_kind_t;

	typedef enum logic [7:0] {
		PH_CTRL    = 8'b0000_0001,
		PH_SECHDR  = 8'b0000_0010,
		PH_SECSKIP = 8'b0000_0100,
		PH_TYPE    = 8'b0000_1000,
		PH_FSET    = 8'b0001_0000,
		PH_CLIPCTL = 8'b0010_0000,
		PH_CLIP    = 8'b0100_0000,
		PH_BODY    = 8'b1000_0000
	} phase_t;

	typedef enum logic [1:0] {
		FK_COORD = 2'd0,
		FK_BYTE  = 2'd1,
		FK_WORD  = 2'd2
	} fkind_t;

	localparam logic [7:0] ORD_SCOPY   = 8'd2;
	localparam logic [7:0] ORD_CCOPY   = 8'd13;
	localparam logic [7:0] ORD_DEFAULT = 8'd1;
	localparam logic signed [16:0] SEC_EXTRA = 17'sd13;
	localparam logic signed [16:0] SEC_HDR   = 17'sd6;

	localparam int F_STD      = 0;
	localparam int F_SEC      = 1;
	localparam int F_CLIP     = 2;
	localparam int F_NEW      = 3;
	localparam int F_DIFF     = 4;
	localparam int F_SAMECLIP = 5;

	typedef struct packed {
		fkind_t     kind;
		logic [4:0] fbit;
		logic [3:0] tgt;
	} fdesc_t;

	typedef struct packed {
		rec_kind_t   kind;
		logic [15:0] dst_x;
		logic [15:0] dst_y;
		logic [15:0] width;
		logic [15:0] height;
		logic [15:0] src_x;
		logic [15:0] src_y;
		logic [7:0]  cache_id;
		logic [15:0] cache_index;
		logic [15:0] order_length;
		logic        last;
	} rec_t;

	typedef struct packed {
		logic [1:0] n;
		rec_t       r0;
		rec_t       r1;
	} rec_pair_t;

	// Entries 0 to 6 belong to the screen copy, 7 to 15 to the cached copy.
	function automatic fdesc_t fdesc(input logic [3:0] i);
		fdesc_t d;
		case (i)
			4'd0:    d = '{FK_COORD, 5'd0, 4'd0};
			4'd1:    d = '{FK_COORD, 5'd1, 4'd1};
			4'd2:    d = '{FK_COORD, 5'd2, 4'd2};
			4'd3:    d = '{FK_COORD, 5'd3, 4'd3};
			4'd4:    d = '{FK_BYTE,  5'd4, 4'd6};
			4'd5:    d = '{FK_COORD, 5'd5, 4'd4};
			4'd6:    d = '{FK_COORD, 5'd6, 4'd5};
			4'd7:    d = '{FK_WORD,  5'd0, 4'd14};
			4'd8:    d = '{FK_COORD, 5'd1, 4'd7};
			4'd9:    d = '{FK_COORD, 5'd2, 4'd8};
			4'd10:   d = '{FK_COORD, 5'd3, 4'd9};
			4'd11:   d = '{FK_COORD, 5'd4, 4'd10};
			4'd12:   d = '{FK_BYTE,  5'd5, 4'd13};
			4'd13:   d = '{FK_COORD, 5'd6, 4'd11};
			4'd14:   d = '{FK_COORD, 5'd7, 4'd12};
			default: d = '{FK_WORD,  5'd8, 4'd15};
		endcase
		return d;
	endfunction

endpackage

/* design/dofd_parser.sv */
// ----------------------------------------------------------------------------
// Drawing order parser
// Holds the order state and turns one stream byte into up to two records.
// ----------------------------------------------------------------------------
module dofd_parser #(
	parameter int NUM_ORDER_TYPES = 32,
	parameter int COORD_BITS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 go,
	input  logic [7:0]           order_byte,
	input  logic                 end_of_buffer,
	output dofd_pkg::rec_pair_t  pair
);
	import dofd_pkg::*;

	localparam int CW = COORD_BITS;

	phase_t             phase_q, n_phase;
	logic [7:0]         cf_q, n_cf;
	logic [23:0]        fpf_q, n_fpf;
	logic [7:0]         ord_q, n_ord;
	logic [15:0]        cnt_q, n_cnt;
	logic [15:0]        part_q, n_part;
	logic [15:0]        obc_q, n_obc;
	logic [4:0]         step_q, n_step;
	logic [7:0]         clipctl_q, n_clipctl;
	logic [CW-1:0]      clip_q [4];
	logic [CW-1:0]      n_clip [4];
	logic [CW-1:0]      scr_q [6];
	logic [CW-1:0]      n_scr [6];
	logic [CW-1:0]      cc_q [6];
	logic [CW-1:0]      n_cc [6];
	logic [15:0]        ids_q [2];
	logic [15:0]        n_ids [2];

	logic               go_type, go_fset, go_clip, go_begin, go_body;
	logic               fail, fin;
	rec_kind_t          fk;
	logic [1:0]         flen;
	logic [15:0]        v;
	logic               done;
	fdesc_t             d;
	logic [1:0]         base;
	logic               found;
	logic [4:0]         fidx;
	logic [1:0]         flen2;
	logic [4:0]         fend;
	logic signed [16:0] sz;
	logic [CW-1:0]      cw_v;
	logic signed [CW-1:0] x0, y0, x1, y1, w, h, cx0, cy0, cx1, cy1;

	function automatic logic [CW-1:0] sx8(input logic [7:0] a);
		return {{(CW-8){a[7]}}, a};
	endfunction

	function automatic logic [CW-1:0] sx16(input logic [15:0] a);
		return {{(CW-16){a[15]}}, a};
	endfunction

	function automatic logic [1:0] blen(input logic [3:0] i, input logic [23:0] f,
			input logic [7:0] c);
		fdesc_t e;
		e = fdesc(i);
		if (!f[e.fbit]) return 2'd0;
		if (e.kind == FK_BYTE) return 2'd1;
		if (e.kind == FK_WORD) return 2'd2;
		return c[F_DIFF] ? 2'd1 : 2'd2;
	endfunction

	function automatic logic [1:0] clen(input logic [1:0] i, input logic [7:0] c);
		if (c[3'd4 + 3'(i)]) return 2'd1;
		return c[i] ? 2'd2 : 2'd0;
	endfunction

	function automatic rec_t mk(input rec_kind_t k, input logic [15:0] a, input logic [15:0] b,
			input logic [15:0] c, input logic [15:0] e, input logic [15:0] f,
			input logic [15:0] g, input logic [7:0] id, input logic [15:0] idx,
			input logic [15:0] len);
		return '{k, a, b, c, e, f, g, id, idx, len, 1'b0};
	endfunction

	always_comb begin
		n_phase = phase_q;
		n_cf = cf_q;
		n_fpf = fpf_q;
		n_ord = ord_q;
		n_cnt = cnt_q;
		n_part = part_q;
		n_step = step_q;
		n_clipctl = clipctl_q;
		n_clip = clip_q;
		n_scr = scr_q;
		n_cc = cc_q;
		n_ids = ids_q;
		go_type = 1'b0;
		go_fset = 1'b0;
		go_clip = 1'b0;
		go_begin = 1'b0;
		go_body = 1'b0;
		fail = 1'b0;
		fin = 1'b0;
		fk = KIND_SHORT;
		flen = 2'd0;
		v = 16'd0;
		done = 1'b0;
		d = fdesc(step_q[3:0]);
		base = 2'd0;
		found = 1'b0;
		fidx = 5'd0;
		flen2 = 2'd0;
		fend = 5'd0;
		sz = 17'sd0;
		cw_v = '0;
		pair = '0;

		if (phase_q == PH_CTRL) begin
			n_obc = 16'd1;
		end else if (obc_q != 16'hffff) begin
			n_obc = obc_q + 16'd1;
		end else begin
			n_obc = obc_q;
		end

		unique case (phase_q)
			PH_CTRL: begin
				if (!order_byte[F_STD]) begin
					fail = 1'b1;
					fk = KIND_NONSTD;
				end else if (order_byte[F_SEC]) begin
					n_part = 16'd0;
					n_phase = PH_SECHDR;
				end else begin
					n_cf = order_byte;
					if (order_byte[F_NEW]) n_phase = PH_TYPE;
					else go_type = 1'b1;
				end
			end
			PH_SECHDR: begin
				sz = $signed({part_q[15], part_q}) + SEC_EXTRA;
				if (n_obc == 16'd2) begin
					n_part = {8'd0, order_byte};
				end else if (n_obc == 16'd3) begin
					n_part = {order_byte, part_q[7:0]};
				end else if (n_obc >= 16'd6) begin
					if (sz < SEC_HDR) begin
						fail = 1'b1;
						fk = KIND_SHORT;
					end else if (sz == SEC_HDR) begin
						fail = 1'b1;
						fk = KIND_SECSKIP;
					end else begin
						n_cnt = 16'(sz - SEC_HDR);
						n_phase = PH_SECSKIP;
					end
				end
			end
			PH_SECSKIP: begin
				if (cnt_q != 16'd0) n_cnt = cnt_q - 16'd1;
				if (n_cnt == 16'd0) begin
					fail = 1'b1;
					fk = KIND_SECSKIP;
				end
			end
			PH_TYPE: begin
				n_ord = ({1'b0, order_byte} >= 9'(NUM_ORDER_TYPES)) ? ORD_DEFAULT : order_byte;
				go_type = 1'b1;
			end
			PH_FSET: begin
				case (step_q[1:0])
					2'd0: n_fpf[7:0] = fpf_q[7:0] | order_byte;
					2'd1: n_fpf[15:8] = fpf_q[15:8] | order_byte;
					2'd2: n_fpf[23:16] = fpf_q[23:16] | order_byte;
					default: n_fpf = fpf_q;
				endcase
				n_step = step_q + 5'd1;
				if (cnt_q != 16'd0) n_cnt = cnt_q - 16'd1;
				if (n_cnt == 16'd0) go_fset = 1'b1;
			end
			PH_CLIPCTL: begin
				n_clipctl = order_byte;
				n_step = 5'd0;
				go_clip = 1'b1;
			end
			PH_CLIP: begin
				flen = clen(step_q[1:0], clipctl_q);
				if (flen == 2'd2 && cnt_q == 16'd2) begin
					n_part = {8'd0, order_byte};
					n_cnt = 16'd1;
				end else begin
					v = (flen == 2'd2) ? {order_byte, part_q[7:0]} : {8'd0, order_byte};
					n_cnt = 16'd0;
					if (flen == 2'd1) begin
						n_clip[step_q[1:0]] = clip_q[step_q[1:0]] + sx8(v[7:0]);
					end else begin
						n_clip[step_q[1:0]] = sx16(v) + CW'(step_q[1]);
					end
					n_step = step_q + 5'd1;
					go_clip = 1'b1;
				end
			end
			PH_BODY: begin
				flen = blen(step_q[3:0], fpf_q, cf_q);
				if (flen == 2'd2 && cnt_q == 16'd2) begin
					n_part = {8'd0, order_byte};
					n_cnt = 16'd1;
				end else begin
					v = (flen == 2'd2) ? {order_byte, part_q[7:0]} : {8'd0, order_byte};
					n_cnt = 16'd0;
					done = 1'b1;
					n_step = step_q + 5'd1;
					go_body = 1'b1;
				end
			end
			default: begin
				n_phase = PH_CTRL;
			end
		endcase

		if (done) begin
			if (d.kind == FK_COORD) begin
				cw_v = sx16(v);
			end else begin
				cw_v = CW'(v);
			end
			case (d.tgt)
				4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5: begin
					if (d.kind == FK_COORD && flen == 2'd1) begin
						n_scr[3'(d.tgt)] = scr_q[3'(d.tgt)] + sx8(v[7:0]);
					end else begin
						n_scr[3'(d.tgt)] = cw_v;
					end
				end
				4'd7, 4'd8, 4'd9, 4'd10, 4'd11, 4'd12: begin
					if (d.kind == FK_COORD && flen == 2'd1) begin
						n_cc[3'(d.tgt - 4'd7)] = cc_q[3'(d.tgt - 4'd7)] + sx8(v[7:0]);
					end else begin
						n_cc[3'(d.tgt - 4'd7)] = cw_v;
					end
				end
				4'd14: n_ids[0] = v;
				4'd15: n_ids[1] = v;
				default: n_ids = n_ids;
			endcase
		end

		if (go_type) begin
			base = (n_ord == ORD_SCOPY) ? 2'd1 : (n_ord == ORD_CCOPY) ? 2'd2 : 2'd0;
			if (n_cf[7:6] > base) begin
				fail = 1'b1;
				fk = KIND_FCOUNT;
			end else begin
				n_fpf = 24'd0;
				if (base != n_cf[7:6]) begin
					n_cnt = 16'(base - n_cf[7:6]);
					n_step = 5'd0;
					n_phase = PH_FSET;
				end else begin
					go_fset = 1'b1;
				end
			end
		end

		if (go_fset) begin
			if (n_cf[F_CLIP] && !n_cf[F_SAMECLIP]) n_phase = PH_CLIPCTL;
			else go_begin = 1'b1;
		end

		if (go_clip) begin
			for (int i = 3; i >= 0; i--) begin
				if (5'(i) >= n_step && clen(2'(i), n_clipctl) != 2'd0) begin
					found = 1'b1;
					fidx = 5'(i);
				end
			end
			if (found) begin
				flen2 = clen(fidx[1:0], n_clipctl);
				n_step = fidx;
				n_cnt = 16'(flen2);
				n_part = 16'd0;
				n_phase = PH_CLIP;
			end else begin
				go_begin = 1'b1;
			end
		end

		if (go_begin) begin
			if (n_ord != ORD_SCOPY && n_ord != ORD_CCOPY) begin
				fail = 1'b1;
				fk = KIND_UNSUP;
			end else begin
				n_step = (n_ord == ORD_SCOPY) ? 5'd0 : 5'd7;
				go_body = 1'b1;
			end
		end

		if (go_body) begin
			found = 1'b0;
			fidx = 5'd0;
			fend = (n_ord == ORD_SCOPY) ? 5'd7 : 5'd16;
			for (int i = 15; i >= 0; i--) begin
				if (5'(i) >= n_step && 5'(i) < fend && blen(4'(i), n_fpf, n_cf) != 2'd0) begin
					found = 1'b1;
					fidx = 5'(i);
				end
			end
			if (found) begin
				flen2 = blen(fidx[3:0], n_fpf, n_cf);
				n_step = fidx;
				n_cnt = 16'(flen2);
				n_part = 16'd0;
				n_phase = PH_BODY;
			end else begin
				fin = 1'b1;
				n_phase = PH_CTRL;
			end
		end

		if (fail) n_phase = PH_CTRL;

		if (n_phase != PH_CTRL && end_of_buffer) begin
			fail = 1'b1;
			fk = KIND_SHORT;
			n_phase = PH_CTRL;
		end

		x0 = n_scr[0];
		y0 = n_scr[1];
		w = n_scr[2];
		h = n_scr[3];
		x1 = n_scr[0] + n_scr[2];
		y1 = n_scr[1] + n_scr[3];
		cx0 = n_clip[0];
		cy0 = n_clip[1];
		cx1 = n_clip[2];
		cy1 = n_clip[3];
		if (n_cf[F_CLIP]) begin
			if (x0 < cx1 && cx0 < x1 && y0 < cy1 && cy0 < y1) begin
				if (cx0 > x0) x0 = cx0;
				if (cy0 > y0) y0 = cy0;
				if (cx1 < x1) x1 = cx1;
				if (cy1 < y1) y1 = cy1;
				w = x1 - x0;
				h = y1 - y0;
			end else begin
				w = '0;
				h = '0;
			end
		end

		if (fail) begin
			pair.n = 2'd1;
			pair.r0 = mk(fk, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 8'd0, 16'd0, n_obc);
			pair.r0.last = 1'b1;
		end else if (fin) begin
			if (n_ord == ORD_SCOPY) begin
				pair.n = 2'd1;
				pair.r0 = mk(KIND_SCOPY, x0[15:0], y0[15:0], w[15:0], h[15:0],
					n_scr[4][15:0], n_scr[5][15:0], 8'd0, 16'd0, n_obc);
				pair.r0.last = 1'b1;
			end else begin
				pair.r0 = mk(KIND_CCOPY, n_cc[0][15:0], n_cc[1][15:0], n_cc[2][15:0],
					n_cc[3][15:0], n_cc[4][15:0], n_cc[5][15:0], n_ids[0][7:0], n_ids[1],
					n_obc);
				if (n_cf[F_CLIP]) begin
					pair.n = 2'd2;
					cx1 = n_clip[2] - n_clip[0];
					cy1 = n_clip[3] - n_clip[1];
					pair.r1 = mk(KIND_CLIP, n_clip[0][15:0], n_clip[1][15:0], cx1[15:0],
						cy1[15:0], 16'd0, 16'd0, 8'd0, 16'd0, n_obc);
					pair.r1.last = 1'b1;
				end else begin
					pair.n = 2'd1;
					pair.r0.last = 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_CTRL;
			cf_q <= 8'd0;
			fpf_q <= 24'd0;
			ord_q <= ORD_DEFAULT;
			cnt_q <= 16'd0;
			part_q <= 16'd0;
			obc_q <= 16'd0;
			step_q <= 5'd0;
			clipctl_q <= 8'd0;
			clip_q <= '{default: '0};
			scr_q <= '{default: '0};
			cc_q <= '{default: '0};
			ids_q <= '{default: '0};
		end else if (go) begin
			phase_q <= n_phase;
			cf_q <= n_cf;
			fpf_q <= n_fpf;
			ord_q <= n_ord;
			cnt_q <= n_cnt;
			part_q <= n_part;
			obc_q <= n_obc;
			step_q <= n_step;
			clipctl_q <= n_clipctl;
			clip_q <= n_clip;
			scr_q <= n_scr;
			cc_q <= n_cc;
			ids_q <= n_ids;
		end
	end

endmodule

/* design/dofd_rec_buf.sv */
// ----------------------------------------------------------------------------
// Drawing order record buffer
// Result register that holds the records of one byte and hands them out in order.
// ----------------------------------------------------------------------------
module dofd_rec_buf (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                go,
	input  dofd_pkg::rec_pair_t pair,
	output logic                free,
	output logic                rec_valid,
	input  logic                rec_stall,
	output dofd_pkg::rec_t      rec
);
	import dofd_pkg::*;

	rec_t       r0_q, r1_q;
	logic [1:0] rem_q;
	logic       sel_q;
	logic       take;

	assign rec_valid = (rem_q != 2'd0);
	assign take = rec_valid && !rec_stall;
	assign free = (rem_q == 2'd0) || (rem_q == 2'd1 && take);
	assign rec = sel_q ? r1_q : r0_q;

	always_ff @(posedge clk) begin
		if (go && free) begin
			r0_q <= pair.r0;
			r1_q <= pair.r1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= 2'd0;
			sel_q <= 1'b0;
		end else if (go && free) begin
			rem_q <= pair.n;
			sel_q <= 1'b0;
		end else if (take) begin
			if (rem_q == 2'd1) begin
				rem_q <= 2'd0;
			end else begin
				rem_q <= 2'd1;
				sel_q <= 1'b1;
			end
		end
	end

endmodule

/* design/drawing_order_field_decoder.sv */
// ----------------------------------------------------------------------------
// Drawing order field decoder
// Parses a remote-desktop primary drawing order stream into copy records.
// ----------------------------------------------------------------------------
// The block takes one stream word per cycle unless byte_stall is high, and
// delivers the records it causes in order: one record for a finished order
// or an error, two for a clipped cached copy. A word passes through an input
// register, the parser logic and a result register before its first record
// is valid. The result register takes a new word's records only once it is
// free, so a word that yields two records holds the input while the result
// register drains.
module drawing_order_field_decoder #(
	parameter int NUM_ORDER_TYPES = 32,
	parameter int COORD_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               byte_valid,
	output logic               byte_stall,
	input  logic [7:0]         order_byte,
	input  logic               end_of_buffer,
	output logic               rec_valid,
	input  logic               rec_stall,
	output logic [2:0]         rec_kind,
	output logic signed [15:0] dst_x,
	output logic signed [15:0] dst_y,
	output logic signed [15:0] width,
	output logic signed [15:0] height,
	output logic signed [15:0] src_x,
	output logic signed [15:0] src_y,
	output logic [7:0]         cache_id,
	output logic [15:0]        cache_index,
	output logic [15:0]        order_length,
	output logic               last
);
	import dofd_pkg::*;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       eob_s1;
	logic       free;
	logic       go;
	rec_pair_t  pair;
	rec_t       rec;

	assign go = valid_s1 && free;
	assign byte_stall = valid_s1 && !free;

	always_ff @(posedge clk) begin
		if (byte_valid && !byte_stall) begin
			byte_s1 <= order_byte;
			eob_s1 <= end_of_buffer;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_valid && !byte_stall) begin
			valid_s1 <= 1'b1;
		end else if (go) begin
			valid_s1 <= 1'b0;
		end
	end

	dofd_parser #(
		.NUM_ORDER_TYPES(NUM_ORDER_TYPES),
		.COORD_BITS(COORD_BITS)
	) u_parser (
		.clk(clk),
		.arst_n(arst_n),
		.go(go),
		.order_byte(byte_s1),
		.end_of_buffer(eob_s1),
		.pair(pair)
	);

	dofd_rec_buf u_rec_buf (
		.clk(clk),
		.arst_n(arst_n),
		.go(go),
		.pair(pair),
		.free(free),
		.rec_valid(rec_valid),
		.rec_stall(rec_stall),
		.rec(rec)
	);

	assign rec_kind = rec.kind;
	assign dst_x = rec.dst_x;
	assign dst_y = rec.dst_y;
	assign width = rec.width;
	assign height = rec.height;
	assign src_x = rec.src_x;
	assign src_y = rec.src_y;
	assign cache_id = rec.cache_id;
	assign cache_index = rec.cache_index;
	assign order_length = rec.order_length;
	assign last = rec.last;

endmodule

/* dv/dofd_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Drawing order field decoder checker
// Watches the byte and record channels, runs its own parser on every
// accepted word and compares each delivered record with the oldest one
// predicted.
// ----------------------------------------------------------------------------
module dofd_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               byte_valid,
	input  logic               byte_stall,
	input  logic [7:0]         order_byte,
	input  logic               end_of_buffer,
	input  logic               rec_valid,
	input  logic               rec_stall,
	input  logic [2:0]         rec_kind,
	input  logic signed [15:0] dst_x,
	input  logic signed [15:0] dst_y,
	input  logic signed [15:0] width,
	input  logic signed [15:0] height,
	input  logic signed [15:0] src_x,
	input  logic signed [15:0] src_y,
	input  logic [7:0]         cache_id,
	input  logic [15:0]        cache_index,
	input  logic [15:0]        order_length,
	input  logic               last,
	output int                 fail_count,
	output int                 pending
);
	import dofd_pkg::*;

	typedef struct packed {
		logic [2:0]  kind;
		logic [15:0] x, y, w, h, sx, sy;
		logic [7:0]  cid;
		logic [15:0] cidx, olen;
		logic        lst;
	} record_t;

	localparam int NTYPES = 32;

	record_t expected_records[$];
	record_t word_recs[$];

	phase_t      phase;
	logic [7:0]  ctl, clipctl, cur_order, rop_s, rop_c;
	logic [23:0] fpres;
	logic [15:0] countdown, partial, obytes;
	logic [15:0] clipw[4], srect[4], ssrc[2], crect[4], csrc[2], cids[2];
	int          fstep;

	function automatic logic [15:0] sx8(input logic [7:0] v);
		return {{8{v[7]}}, v};
	endfunction

	function automatic void add_rec(input logic [2:0] k, input logic [15:0] x, y, w, h, a, b,
			input logic [7:0] cid, input logic [15:0] cidx);
		record_t r;
		if (word_recs.size() >= 2)
			return;
		r = '{k, x, y, w, h, a, b, cid, cidx, obytes, 1'b0};
		word_recs.push_back(r);
	endfunction

	function automatic void abort_order(input logic [2:0] k);
		add_rec(k, 0, 0, 0, 0, 0, 0, 0, 0);
		phase = PH_CTRL;
	endfunction

	function automatic int field_len(input int i);
		fdesc_t d;
		d = fdesc(4'(i));
		if (!fpres[d.fbit])
			return 0;
		if (d.kind == FK_BYTE)
			return 1;
		if (d.kind == FK_WORD)
			return 2;
		return ctl[F_DIFF] ? 1 : 2;
	endfunction

	function automatic int clip_len(input int i);
		if (clipctl[4 + (i & 3)])
			return 1;
		return clipctl[i & 3] ? 2 : 0;
	endfunction

	function automatic void finish_order();
		int x0, y0, x1, y1, w, h, cx0, cy0, cx1, cy1;
		if (cur_order == ORD_SCOPY) begin
			x0 = $signed(srect[0]);
			y0 = $signed(srect[1]);
			x1 = $signed(16'(srect[0] + srect[2]));
			y1 = $signed(16'(srect[1] + srect[3]));
			w = $signed(srect[2]);
			h = $signed(srect[3]);
			if (ctl[F_CLIP]) begin
				cx0 = $signed(clipw[0]);
				cy0 = $signed(clipw[1]);
				cx1 = $signed(clipw[2]);
				cy1 = $signed(clipw[3]);
				if (x0 < cx1 && cx0 < x1 && y0 < cy1 && cy0 < y1) begin
					if (cx0 > x0) x0 = cx0;
					if (cy0 > y0) y0 = cy0;
					if (cx1 < x1) x1 = cx1;
					if (cy1 < y1) y1 = cy1;
					w = x1 - x0;
					h = y1 - y0;
				end else begin
					w = 0;
					h = 0;
				end
			end
			add_rec(KIND_SCOPY, 16'(x0), 16'(y0), 16'(w), 16'(h), ssrc[0], ssrc[1], 0, 0);
		end else begin
			add_rec(KIND_CCOPY, crect[0], crect[1], crect[2], crect[3], csrc[0], csrc[1],
				cids[0][7:0], cids[1]);
			if (ctl[F_CLIP])
				add_rec(KIND_CLIP, clipw[0], clipw[1], 16'(clipw[2] - clipw[0]),
					16'(clipw[3] - clipw[1]), 0, 0, 0, 0);
		end
		phase = PH_CTRL;
	endfunction

	function automatic void body_seek();
		int stop;
		stop = (cur_order == ORD_SCOPY) ? 7 : 16;
		while (fstep < stop && field_len(fstep) == 0)
			fstep++;
		if (fstep < stop) begin
			countdown = 16'(field_len(fstep));
			partial = 0;
			phase = PH_BODY;
		end else
			finish_order();
	endfunction

	function automatic void begin_body();
		if (cur_order != ORD_SCOPY && cur_order != ORD_CCOPY) begin
			abort_order(KIND_UNSUP);
			return;
		end
		fstep = (cur_order == ORD_SCOPY) ? 0 : 7;
		body_seek();
	endfunction

	function automatic void clip_seek();
		while (fstep < 4 && clip_len(fstep) == 0)
			fstep++;
		if (fstep < 4) begin
			countdown = 16'(clip_len(fstep));
			partial = 0;
			phase = PH_CLIP;
		end else
			begin_body();
	endfunction

	function automatic void after_fset();
		if (ctl[F_CLIP] && !ctl[F_SAMECLIP])
			phase = PH_CLIPCTL;
		else
			begin_body();
	endfunction

	function automatic void after_type();
		int base, fs;
		base = (cur_order == ORD_SCOPY) ? 1 : (cur_order == ORD_CCOPY) ? 2 : 0;
		fs = base - int'(ctl[7:6]);
		if (fs < 0) begin
			abort_order(KIND_FCOUNT);
			return;
		end
		fpres = 0;
		if (fs > 0) begin
			countdown = 16'(fs);
			fstep = 0;
			phase = PH_FSET;
		end else
			after_fset();
	endfunction

	// Collects one word of a one- or two-word field; returns 1 when complete.
	function automatic bit collect(input logic [7:0] b, input int len, output logic [15:0] v);
		v = 0;
		if (len == 2 && countdown == 2) begin
			partial = {8'd0, b};
			countdown = 1;
			return 0;
		end
		v = (len == 2) ? {b, partial[7:0]} : {8'd0, b};
		countdown = 0;
		return 1;
	endfunction

	function automatic void store_field(input int t, input logic [15:0] val, input int len,
			input fkind_t k);
		logic [15:0] old, nv;
		case (t)
			0, 1, 2, 3: old = srect[t];
			4, 5: old = ssrc[t - 4];
			7, 8, 9, 10: old = crect[t - 7];
			11, 12: old = csrc[t - 11];
			14: old = cids[0];
			15: old = cids[1];
			default: old = 0;
		endcase
		if (k == FK_COORD)
			nv = (len == 1) ? old + sx8(val[7:0]) : val;
		else
			nv = val;
		case (t)
			0, 1, 2, 3: srect[t] = nv;
			4, 5: ssrc[t - 4] = nv;
			6: rop_s = nv[7:0];
			7, 8, 9, 10: crect[t - 7] = nv;
			11, 12: csrc[t - 11] = nv;
			13: rop_c = nv[7:0];
			14: cids[0] = nv;
			default: cids[1] = nv;
		endcase
	endfunction

	function automatic void parse_word(input logic [7:0] b, input logic eob);
		logic [15:0] v;
		int len, i, size;
		fdesc_t d;
		word_recs.delete();
		if (phase == PH_CTRL)
			obytes = 1;
		else if (obytes != 16'hffff)
			obytes++;
		case (phase)
			PH_CTRL: begin
				if (!b[F_STD])
					abort_order(KIND_NONSTD);
				else if (b[F_SEC]) begin
					partial = 0;
					phase = PH_SECHDR;
				end else begin
					ctl = b;
					if (b[F_NEW])
						phase = PH_TYPE;
					else
						after_type();
				end
			end
			PH_SECHDR: begin
				if (obytes == 2)
					partial = {8'd0, b};
				else if (obytes == 3)
					partial = {b, partial[7:0]};
				else if (obytes >= 6) begin
					size = $signed(partial) + 13;
					if (size < 6)
						abort_order(KIND_SHORT);
					else if (size == 6)
						abort_order(KIND_SECSKIP);
					else begin
						countdown = 16'(size - 6);
						phase = PH_SECSKIP;
					end
				end
			end
			PH_SECSKIP: begin
				if (countdown > 0)
					countdown--;
				if (countdown == 0)
					abort_order(KIND_SECSKIP);
			end
			PH_TYPE: begin
				cur_order = (b >= NTYPES) ? ORD_DEFAULT : b;
				after_type();
			end
			PH_FSET: begin
				fpres = fpres | 24'({24'd0, b} << (8 * (fstep & 3)));
				fstep++;
				if (countdown > 0)
					countdown--;
				if (countdown == 0)
					after_fset();
			end
			PH_CLIPCTL: begin
				clipctl = b;
				fstep = 0;
				clip_seek();
			end
			PH_CLIP: begin
				len = clip_len(fstep);
				if (collect(b, len, v)) begin
					i = fstep & 3;
					if (len == 1)
						clipw[i] = clipw[i] + sx8(v[7:0]);
					else
						clipw[i] = v + ((i >= 2) ? 16'd1 : 16'd0);
					fstep++;
					clip_seek();
				end
			end
			default: begin
				len = field_len(fstep);
				if (collect(b, len, v)) begin
					d = fdesc(4'(fstep));
					store_field(int'(d.tgt), v, len, d.kind);
					fstep++;
					body_seek();
				end
			end
		endcase
		if (phase != PH_CTRL && eob)
			abort_order(KIND_SHORT);
		foreach (word_recs[k]) begin
			word_recs[k].lst = (k == word_recs.size() - 1);
			expected_records.push_back(word_recs[k]);
		end
	endfunction

	record_t got, want;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase = PH_CTRL;
			ctl = 0;
			clipctl = 0;
			cur_order = ORD_DEFAULT;
			rop_s = 0;
			rop_c = 0;
			fpres = 0;
			countdown = 0;
			partial = 0;
			obytes = 0;
			fstep = 0;
			foreach (clipw[k]) begin
				clipw[k] = 0;
				srect[k] = 0;
				crect[k] = 0;
			end
			foreach (ssrc[k]) begin
				ssrc[k] = 0;
				csrc[k] = 0;
				cids[k] = 0;
			end
			expected_records.delete();
			fail_count = 0;
			pending = 0;
		end else begin
			if (rec_valid && !rec_stall) begin
				got = '{rec_kind, dst_x, dst_y, width, height, src_x, src_y, cache_id,
					cache_index, order_length, last};
				if (expected_records.size() == 0) begin
					$display("%0t: unexpected record %h", $time, got);
					fail_count++;
				end else begin
					want = expected_records.pop_front();
					if (got !== want) begin
						$display("%0t: record mismatch expected %h actual %h", $time, want,
							got);
						fail_count++;
					end
				end
			end
			if (byte_valid && !byte_stall)
				parse_word(order_byte, end_of_buffer);
			pending = expected_records.size();
		end
	end

endmodule

/* dv/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Drawing order field decoder testbench
// Feeds directed and random drawing order streams with bursty input and
// random output stalls; the checker predicts and compares every record.
// ----------------------------------------------------------------------------
module testbench;
	import dofd_pkg::*;

	logic               clk = 0;
	logic               arst_n = 0;
	logic               byte_valid = 0;
	logic               byte_stall;
	logic [7:0]         order_byte = 0;
	logic               end_of_buffer = 0;
	logic               rec_valid;
	logic               rec_stall = 0;
	logic [2:0]         rec_kind;
	logic signed [15:0] dst_x, dst_y, width, height, src_x, src_y;
	logic [7:0]         cache_id;
	logic [15:0]        cache_index, order_length;
	logic               last;
	int                 fail_count, pending;
	int                 cycles = 0;
	int                 gap_left = 0;
	int                 words_sent = 0;
	bit                 hold_off = 0;

	always #5 clk = ~clk;

	drawing_order_field_decoder DUT (.*);

	dofd_checker checker_i (.*);

	always @(posedge clk) begin
		cycles++;
		if (cycles > 400000) begin
			$display("testbench: errors");
			$finish;
		end
	end

	// Output stall pattern, plus one long hold-off early in the random part.
	always @(negedge clk) begin
		if (hold_off)
			rec_stall <= 1;
		else
			case (cycles / 500 % 3)
				0: rec_stall <= 0;
				1: rec_stall <= ($urandom_range(0, 3) == 0);
				default: rec_stall <= ($urandom_range(0, 1) == 0);
			endcase
	end

	initial begin
		@(posedge clk);
		wait (cycles == 400);
		hold_off = 1;
		repeat (200) @(posedge clk);
		hold_off = 0;
	end

	task automatic send_word(input logic [7:0] b, input logic eob);
		if (gap_left == 0 && $urandom_range(0, 5) == 0) begin
			byte_valid <= 0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
			gap_left = $urandom_range(1, 30);
		end
		if (gap_left > 0)
			gap_left--;
		byte_valid <= 1;
		order_byte <= b;
		end_of_buffer <= eob;
		@(posedge clk);
		while (byte_stall)
			@(posedge clk);
		words_sent++;
		@(negedge clk);
	endtask

	task automatic send_coord(input bit delta);
		if (delta)
			send_word(8'($urandom), 0);
		else begin
			send_word(8'($urandom), 0);
			send_word(8'($urandom), 0);
		end
	endtask

	// A well-formed primary order with random content.
	task automatic send_primary_order();
		logic [7:0] c, ord, cc;
		logic [15:0] fp;
		int nf, nfields;
		c = 8'($urandom) | 8'h01;
		c[F_SEC] = 0;
		c[7:6] = ($urandom_range(0, 7) == 0) ? 2'($urandom) : 2'd0;
		if ($urandom_range(0, 1)) begin
			c[F_NEW] = 1;
			case ($urandom_range(0, 9))
				0: ord = 8'($urandom);
				1, 2, 3, 4: ord = ORD_SCOPY;
				default: ord = ORD_CCOPY;
			endcase
		end else begin
			c[F_NEW] = 0;
			ord = 0;
		end
		send_word(c, 0);
		if (c[F_NEW])
			send_word(ord, 0);
		if (c[F_NEW])
			nf = (ord == ORD_SCOPY) ? 1 : (ord == ORD_CCOPY) ? 2 : 0;
		else
			nf = 1;
		nf = nf - int'(c[7:6]);
		if (nf < 0)
			nf = 0;
		fp = 16'($urandom);
		for (int k = 0; k < nf; k++)
			send_word(fp[8 * k +: 8], 0);
		if (c[F_CLIP] && !c[F_SAMECLIP]) begin
			cc = 8'($urandom);
			send_word(cc, 0);
			for (int k = 0; k < 4; k++)
				if (cc[4 + k])
					send_word(8'($urandom), 0);
				else if (cc[k])
					send_coord(0);
		end
		// Enough body words for the longest order; surplus starts new orders.
		nfields = $urandom_range(0, 18);
		for (int k = 0; k < nfields; k++)
			send_word(8'($urandom), ($urandom_range(0, 60) == 0));
	endtask

	task automatic send_secondary(input int len);
		send_word(8'h03, 0);
		send_word(len[7:0], 0);
		send_word(len[15:8], 0);
		send_word(8'($urandom), 0);
		send_word(8'($urandom), 0);
		for (int k = 0; k < len + 7 && k < 40; k++)
			send_word(8'($urandom), 0);
	endtask

	initial begin
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1;
		@(negedge clk);
		// Directed: nonstandard, secondary sizes, field count, unsupported order
		// with a clip window, short orders.
		send_word(8'h00, 0);
		send_word(8'hfe, 1);
		send_secondary(-13);
		send_secondary(-7);
		send_secondary(-8);
		send_secondary(2);
		send_word(8'hc9, 0);
		send_word(ORD_SCOPY, 0);
		send_word(8'h49, 0);
		send_word(8'd5, 0);
		send_word(8'h0d, 0);
		send_word(8'hff, 0);
		send_word(8'h0f, 0);
		for (int k = 0; k < 8; k++)
			send_word(k[0] ? 8'h7f : 8'h80, 0);
		send_word(8'h0d, 0);
		send_word(ORD_SCOPY, 0);
		send_word(8'h7f, 1);
		send_word(8'hff, 0);
		send_word(8'hff, 1);
		while (words_sent < 1030 && cycles < 300000) begin
			case ($urandom_range(0, 9))
				0: send_word(8'($urandom), ($urandom_range(0, 3) == 0));
				1: send_secondary($urandom_range(0, 1) ? $urandom_range(0, 30)
					: int'($signed(16'($urandom))));
				default: send_primary_order();
			endcase
		end
		send_word(8'h0d, 1);
		byte_valid <= 0;
		wait (pending == 0);
		repeat (20) @(posedge clk);
		if (fail_count == 0)
			$display("testbench: clean");
		else
			$display("testbench: errors");
		$finish;
	end

endmodule

/* filelist.f */
design/dofd_pkg.sv
design/dofd_parser.sv
design/dofd_rec_buf.sv
design/drawing_order_field_decoder.sv
dv/dofd_checker.sv
dv/testbench.sv
